### rtl/core/stl_pkg.sv
// Package for the skewed Student t likelihood core.
// Holds status codes, register indexes and the normalizing constant table.
package stl_pkg;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2,
        ST_RSVD = 2'd3
    } t_status;

    localparam logic [0:0] REG_HALF_DOF = 1'b0;
    localparam logic [0:0] REG_SKEW     = 1'b1;

    // C(h) in UQ0.32 for h = 1..16
    function automatic logic [31:0] norm_const(input logic [3:0] idx);
        logic [31:0] c;
        unique case (idx)
            4'd0:  c = 32'd1367131706;
            4'd1:  c = 32'd1578627717;
            4'd2:  c = 32'd1630399696;
            4'd3:  c = 32'd1653527088;
            4'd4:  c = 32'd1666598651;
            4'd5:  c = 32'd1674994668;
            4'd6:  c = 32'd1680841087;
            4'd7:  c = 32'd1685145422;
            4'd8:  c = 32'd1688446400;
            4'd9:  c = 32'd1691058075;
            4'd10: c = 32'd1693175868;
            4'd11: c = 32'd1694927730;
            4'd12: c = 32'd1696400944;
            4'd13: c = 32'd1697657071;
            4'd14: c = 32'd1698740795;
            default: c = 32'd1699685329;
        endcase
        return c;
    endfunction

endpackage

### rtl/core/stl_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing but its parameters.
module stl_div #(
    parameter int NW = 64,
    parameter int DW = 48,
    parameter int TW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);
    logic [NW:0]   r_vld;
    logic [DW-1:0] r_rem [NW+1];
    logic [NW-1:0] r_num [NW+1];
    logic [DW-1:0] r_den [NW+1];
    logic [TW-1:0] r_tag [NW+1];

    always_comb begin
        r_vld[0] = i_valid;
        r_rem[0] = '0;
        r_num[0] = i_num;
        r_den[0] = i_den;
        r_tag[0] = i_tag;
    end

    for (genvar g = 0; g < NW; g++) begin : g_stage
        logic [DW:0] n_trial;
        logic        n_ge;
        assign n_trial = {r_rem[g], r_num[g][NW-1]};
        assign n_ge    = n_trial >= {1'b0, r_den[g]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1] <= n_ge ? DW'(n_trial - {1'b0, r_den[g]}) : DW'(n_trial);
                r_num[g+1] <= {r_num[g][NW-2:0], n_ge};
                r_den[g+1] <= r_den[g];
                r_tag[g+1] <= r_tag[g];
            end
        end
    end

    assign o_valid = r_vld[NW];
    assign o_quo   = r_num[NW];
    assign o_tag   = r_tag[NW];
endmodule

### rtl/core/skewed_t_likelihood_core.sv
// Top level of the skewed Student t likelihood core.
// Uses stl_pkg and three stl_div pipelines.
//
// channel   | direction | payload
// s_axis    | in        | tdata[15:0] residual, tdata[31:16] scale
// m_axis    | out       | tdata[31:0] likelihood, tuser[1:0] status
// cfg       | in        | index 0 half_dof, 1 skew_factor_q
//
// One item per cycle when not stalled. A request passes stage A, divider 1,
// stage B, divider 2, the power chain of MAX_HALF_DOF multiply stages, stages
// M and N, divider 3 and the output register; the dividers are bit-per-stage
// with 64 stages each. A stall freezes the whole pipeline; while a
// result waits at the output, hold off new requests.
// Reset is synchronous active low, clears valid bits and sets half_dof 2, skew 4096.
module skewed_t_likelihood_core
    import stl_pkg::*;
#(
    parameter int MAX_HALF_DOF = 8,
    parameter int FRAC_BITS    = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // residual[15:0], scale[31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // likelihood[31:0]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int HW = $clog2(MAX_HALF_DOF + 1);
    localparam int TAGW = 1 + 1 + HW + 16 + 16; // zero, pos, h, s, k

    logic [3:0]  r_half_dof;
    logic [15:0] r_skew;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_dof <= 4'd2;
            r_skew     <= 16'd4096;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_HALF_DOF) r_half_dof <= i_cfg_data[3:0];
            else                             r_skew     <= i_cfg_data;
        end
    end

    // Pipeline advances whenever the output register can take a result.
    logic en;
    logic r_ovalid;
    assign en = !r_ovalid || m_axis_tready;
    assign s_axis_tready = en;

    // Stage A: operand prep for |x| = num/quo.
    logic [15:0] in_res, in_s, k_eff, mag;
    logic [HW-1:0] h_eff;
    logic pos;
    assign in_res = s_axis_tdata[15:0];
    assign in_s   = s_axis_tdata[31:16];
    assign k_eff  = (r_skew == 16'd0) ? 16'd1 : r_skew;
    always_comb begin
        if (r_half_dof == 4'd0) h_eff = HW'(1);
        else if (32'(r_half_dof) > MAX_HALF_DOF) h_eff = HW'(MAX_HALF_DOF);
        else h_eff = HW'(r_half_dof);
    end
    assign pos = (in_res != 16'd0) && !in_res[15];
    assign mag = in_res[15] ? 16'(17'h10000 - {1'b0, in_res}) : in_res;

    logic          r_a_v, r_a_pos, r_a_zero;
    logic [31:0]   r_a_num, r_a_quo;
    logic [HW-1:0] r_a_h;
    logic [15:0]   r_a_s, r_a_k;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_v <= 1'b0;
        else if (en) r_a_v <= s_axis_tvalid;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_pos  <= pos;
            r_a_zero <= (in_s == 16'd0);
            r_a_num  <= pos ? 32'({mag, FRAC_BITS'(0)}) : mag * k_eff;
            r_a_quo  <= pos ? in_s * k_eff : 32'({in_s, FRAC_BITS'(0)});
            r_a_h    <= h_eff;
            r_a_s    <= in_s;
            r_a_k    <= k_eff;
        end
    end

    // Divider 1: a = (num<<16)/quo, zero quo forced to 1 (item flagged).
    logic          d1_v;
    logic [63:0]   d1_q;
    logic [TAGW-1:0] d1_tag;
    stl_div #(.NW(64), .DW(32), .TW(TAGW)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_a_v),
        .i_num({r_a_num, 32'd0} >> 16),
        .i_den(r_a_quo == 32'd0 ? 32'd1 : r_a_quo),
        .i_tag({r_a_zero, r_a_pos, r_a_h, r_a_s, r_a_k}),
        .o_valid(d1_v), .o_quo(d1_q), .o_tag(d1_tag));

    // Stage B: saturate a, square.
    logic [31:0] a_sat;
    assign a_sat = (d1_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : d1_q[31:0];
    logic r_b_v;
    logic [63:0] r_b_sq;
    logic [TAGW-1:0] r_b_tag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_v <= 1'b0;
        else if (en) r_b_v <= d1_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_sq  <= a_sat * a_sat;
            r_b_tag <= d1_tag;
        end
    end

    // Divider 2: t = v*2^47 / (v*2^16 + y).
    logic [HW-1:0] b_h;
    logic [HW:0]   b_v;
    assign b_h = r_b_tag[32 +: HW];
    assign b_v = {b_h, 1'b0} - (HW+1)'(1);
    logic          d2_v;
    logic [63:0]   d2_q;
    logic [TAGW-1:0] d2_tag;
    stl_div #(.NW(64), .DW(64), .TW(TAGW)) u_div_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_b_v),
        .i_num(64'(b_v) << 47),
        .i_den((64'(b_v) << 16) + (r_b_sq >> 16)),
        .i_tag(r_b_tag),
        .o_valid(d2_v), .o_quo(d2_q), .o_tag(d2_tag));

    // Power chain: MAX_HALF_DOF stages, stage j multiplies when j < h.
    logic          r_p_v   [MAX_HALF_DOF+1];
    logic [31:0]   r_p_p   [MAX_HALF_DOF+1];
    logic [31:0]   r_p_t   [MAX_HALF_DOF+1];
    logic [TAGW-1:0] r_p_tag [MAX_HALF_DOF+1];
    always_comb begin
        r_p_v[0]   = d2_v;
        r_p_p[0]   = 32'h8000_0000;
        r_p_t[0]   = d2_q[31:0];
        r_p_tag[0] = d2_tag;
    end
    for (genvar j = 0; j < MAX_HALF_DOF; j++) begin : g_pow
        logic [63:0] prod;
        assign prod = r_p_p[j] * r_p_t[j];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_p_v[j+1] <= 1'b0;
            else if (en) r_p_v[j+1] <= r_p_v[j];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_p_p[j+1]   <= (32'(j) < 32'(r_p_tag[j][32 +: HW])) ?
                                32'(prod >> 31) : r_p_p[j];
                r_p_t[j+1]   <= r_p_t[j];
                r_p_tag[j+1] <= r_p_tag[j];
            end
        end
    end

    // Stage M: m = (C(h)*p) >> 31, and k^2 / den parts.
    logic [TAGW-1:0] pt;
    assign pt = r_p_tag[MAX_HALF_DOF];
    logic [HW-1:0] m_h;
    assign m_h = pt[32 +: HW];
    logic r_m_v, r_m_zero, r_m_pos;
    logic [32:0] r_m_m;
    logic [31:0] r_m_kk;
    logic [15:0] r_m_s;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m_v <= 1'b0;
        else if (en) r_m_v <= r_p_v[MAX_HALF_DOF];
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_m    <= 33'((64'(norm_const(4'(m_h - HW'(1)))) *
                        64'(r_p_p[MAX_HALF_DOF])) >> 31);
            r_m_kk   <= pt[15:0] * pt[15:0];
            r_m_s    <= pt[31:16];
            r_m_zero <= pt[TAGW-1];
            r_m_pos  <= pt[TAGW-2];
        end
    end

    // Stage N: numerator and denominator of the final quotient.
    logic r_n_v, r_n_zero;
    logic [63:0] r_n_num;
    logic [63:0] r_n_den;
    logic [32:0] den_k;
    assign den_k = {1'b0, r_m_kk} + 33'(64'd1 << (2*FRAC_BITS));
    localparam int SH_P = 3*FRAC_BITS - 15;
    localparam int SH_N = 15 - FRAC_BITS;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_n_v <= 1'b0;
        else if (en) r_n_v <= r_m_v;
    end
    // Negative branch: f = m*k^2/(den << SH_N), or (m*k^2 << -SH_N)/den if SH_N < 0.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_zero <= r_m_zero;
            if (r_m_pos) begin
                r_n_num <= 64'(r_m_m) << SH_P;
                r_n_den <= 64'(den_k) * 64'(r_m_s);
            end else if (SH_N >= 0) begin
                r_n_num <= 64'(r_m_m) * 64'(r_m_kk);
                r_n_den <= (64'(den_k) * 64'(r_m_s)) << (SH_N >= 0 ? SH_N : 0);
            end else begin
                r_n_num <= (64'(r_m_m) * 64'(r_m_kk)) << (SH_N < 0 ? -SH_N : 0);
                r_n_den <= 64'(den_k) * 64'(r_m_s);
            end
        end
    end

    logic        d3_v;
    logic [63:0] d3_q;
    logic [0:0]  d3_tag;
    stl_div #(.NW(64), .DW(64), .TW(1)) u_div_f (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_n_v),
        .i_num(r_n_num),
        .i_den(r_n_den == 64'd0 ? 64'd1 : r_n_den),
        .i_tag(r_n_zero),
        .o_valid(d3_v), .o_quo(d3_q), .o_tag(d3_tag));

    // Output register.
    logic [31:0] r_olik;
    t_status     r_ost;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (en) r_ovalid <= d3_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (d3_tag[0]) begin
                r_olik <= 32'd0;
                r_ost  <= ST_ZERO;
            end else if (d3_q[63:32] != 32'd0) begin
                r_olik <= 32'hFFFF_FFFF;
                r_ost  <= ST_SAT;
            end else begin
                r_olik <= d3_q[31:0];
                r_ost  <= ST_OK;
            end
        end
    end
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_olik;
    assign m_axis_tuser  = r_ost;
endmodule

### rtl/core/stl_checker.sv
// Port checker for the skewed Student t likelihood core.
// Depends on stl_pkg; bound to the top level below.
module stl_checker
    import stl_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_ZERO |-> m_axis_tdata == 32'd0)
        else $error("zero scale with nonzero value");
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_SAT |-> m_axis_tdata == 32'hFFFF_FFFF)
        else $error("saturated without max value");
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != ST_RSVD)
        else $error("reserved status");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("stalled with empty output");
endmodule

bind skewed_t_likelihood_core stl_checker u_stl_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser));

### tb/skewed_t_likelihood_core_test.sv
// Testbench for the skewed Student t likelihood core.
// Depends on stl_pkg and skewed_t_likelihood_core; self-checking, no files read.
`timescale 1ns / 1ps

module skewed_t_likelihood_core_test;
    import stl_pkg::*;

    localparam int MAX_HDOF = 8;
    localparam int FBITS    = 12;
    localparam int DRAIN_CYCLES = 400;  // settle time after the scoreboard empties

    typedef struct packed {
        logic [31:0] likelihood;
        t_status     status;
    } density_t;

    // Holds predicted densities in request order and checks results against them.
    class density_scoreboard;
        density_t pending[$];
        int       errors = 0;

        function void note(density_t d);
            pending.push_back(d);
        endfunction

        function void check(logic [31:0] lik, logic [1:0] st);
            density_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result likelihood=%h status=%0d", $time, lik, st);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (lik !== e.likelihood) begin
                $display("%0t: likelihood expected %h actual %h", $time, e.likelihood, lik);
                errors++;
            end
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // residual[15:0], scale[31:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;       // likelihood[31:0]
    logic [1:0]  m_axis_tuser;       // status[1:0]
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;

    // Configuration copy used by the predictor
    logic [3:0]  cur_hdof = 4'd2;
    logic [15:0] cur_skew = 16'd4096;
    bit          allow_idle = 1'b1;

    density_scoreboard sb = new();

    skewed_t_likelihood_core dut (.*);

    always #5 i_clk = ~i_clk;

    // Compute the skewed t density for one request under the current registers.
    function automatic density_t predict_density(logic [15:0] resid, logic [15:0] sigma,
                                                 logic [3:0] hreg, logic [15:0] kreg);
        logic [63:0] k, h, v, mag, num, quo, a, y, d, t, p, m, den, f, s;
        bit          pos;
        density_t    r;
        s = {48'd0, sigma};
        if (s == 0) begin
            r.likelihood = '0;
            r.status = ST_ZERO;
            return r;
        end
        // zero skew acts as the smallest step; clamp the dof register
        k = (kreg == 0) ? 64'd1 : {48'd0, kreg};
        h = {60'd0, hreg};
        if (h < 1) h = 1;
        if (h > MAX_HDOF) h = MAX_HDOF;
        v = 2 * h - 1;
        // zero residual takes the sigma/k branch
        pos = (resid != 0) && !resid[15];
        mag = resid[15] ? (64'h10000 - resid) : {48'd0, resid};
        if (pos) begin
            num = mag << FBITS;
            quo = s * k;
        end else begin
            num = mag * k;
            quo = s << FBITS;
        end
        a = (num << 16) / quo;
        if (a > 64'hFFFF_FFFF) a = 64'hFFFF_FFFF;
        y = (a * a) >> 16;
        d = (v << 16) + y;
        t = (v << 47) / d;
        p = 64'd1 << 31;
        for (int i = 0; i < h; i++) p = (p * t) >> 31;
        m = ({32'd0, norm_const(4'(h - 1))} * p) >> 31;
        den = (k * k + (64'd1 << (2 * FBITS))) * s;
        if (pos) f = (m << (3 * FBITS - 15)) / den;
        else     f = (m * k * k) / (den << (15 - FBITS));
        if (f > 64'hFFFF_FFFF) begin
            r.likelihood = 32'hFFFF_FFFF;
            r.status = ST_SAT;
        end else begin
            r.likelihood = f[31:0];
            r.status = ST_OK;
        end
        return r;
    endfunction

    // Send one request; insert a random idle burst first when idling is allowed.
    task automatic send_item(logic [15:0] resid, logic [15:0] sigma);
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sigma, resid};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note(predict_density(resid, sigma, cur_hdof, cur_skew));
    endtask

    task automatic write_reg(logic idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_HALF_DOF) cur_hdof = data[3:0];
        else                     cur_skew = data;
    endtask

    // Hold the sender until every predicted result has come back, then settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random(int count);
        logic [15:0] resid, sigma;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 3))
                0: resid = 16'($urandom);
                1: resid = 16'($signed($urandom_range(0, 2048)) - 1024);
                default: resid = 16'($signed($urandom_range(0, 32768)) - 16384);
            endcase
            case ($urandom_range(0, 9))
                0: sigma = 16'd0;
                1: sigma = 16'($urandom_range(1, 64));
                2, 3: sigma = 16'($urandom);
                default: sigma = 16'($urandom_range(1024, 16384));
            endcase
            send_item(resid, sigma);
        end
    endtask

    // Receiver readiness: random stall bursts, steady high in the last phase.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!allow_idle) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Check each accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check(m_axis_tdata, m_axis_tuser);
    end

    initial begin
        logic [15:0] edge_resid[5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
        logic [15:0] edge_sigma[4] = '{16'd0, 16'd1, 16'hFFFF, 16'd4096};
        logic [3:0]  hdof_set[8]   = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2, 4'd7};
        logic [15:0] skew_set[8]   = '{16'd4096, 16'd1, 16'hFFFF, 16'd0,
                                       16'd2048, 16'd8192, 16'd4000, 16'd12288};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes under reset registers
        foreach (edge_resid[i])
            foreach (edge_sigma[j])
                send_item(edge_resid[i], edge_sigma[j]);
        drain();

        // Random phases across register settings, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_HALF_DOF, {12'd0, hdof_set[ph]});
            write_reg(REG_SKEW, skew_set[ph]);
            if (ph == 7) allow_idle = 1'b0;
            // a few extremes under each setting
            send_item(16'h8000, 16'd1);
            send_item(16'h7FFF, 16'd1);
            send_item(16'h0000, 16'hFFFF);
            send_random(175);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
